### rtl/core/rm2q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rm2q_pkg;

    // Fixed-point format of the rotation entries and quaternion parts.
    localparam int FRAC_BITS = 22;

    // Field widths.
    localparam int R_W   = FRAC_BITS + 2;   // matrix entry, signed
    localparam int POS_W = 32;              // translation component
    localparam int MAG_W = FRAC_BITS + 1;   // quaternion magnitude, up to ONE
    localparam int Q_W   = FRAC_BITS + 2;   // signed quaternion vector part
    localparam int THR_W = FRAC_BITS;       // zero threshold register

    // Internal widths.
    localparam int T_W    = R_W + 3;                 // signed trace combination
    localparam int D_W    = R_W + 1;                 // off-diagonal difference
    localparam int ABS_W  = T_W - 1;                 // magnitude of a combination
    localparam int RAD_W  = ABS_W + FRAC_BITS - 2;   // square root radicand
    localparam int ROOT_W = (RAD_W + 1) / 2;         // square root result
    localparam int SQ_W   = 2 * ROOT_W;              // radicand padded to even width
    localparam int REM_W  = ROOT_W + 2;              // square root remainder
    localparam int SAT_W  = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;

    // The value one in the formats used below.
    localparam logic signed [T_W-1:0] ONE_T = T_W'(1) << FRAC_BITS;
    localparam logic [SAT_W-1:0]      ONE_S = SAT_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0]      ONE_M = MAG_W'(1) << FRAC_BITS;
    localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

    // Three-way sign: nz low means zero, otherwise neg selects the sign.
    typedef struct packed {
        logic neg;
        logic nz;
    } t_sgn;

    localparam t_sgn SGN_POS = '{neg: 1'b0, nz: 1'b1};

    // Input transaction.
    typedef struct packed {
        logic signed [R_W-1:0]   r00;
        logic signed [R_W-1:0]   r01;
        logic signed [R_W-1:0]   r02;
        logic signed [R_W-1:0]   r10;
        logic signed [R_W-1:0]   r11;
        logic signed [R_W-1:0]   r12;
        logic signed [R_W-1:0]   r20;
        logic signed [R_W-1:0]   r21;
        logic signed [R_W-1:0]   r22;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in;

    // Output transaction.
    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
        logic [MAG_W-1:0]        quat_w;
        logic signed [Q_W-1:0]   quat_x;
        logic signed [Q_W-1:0]   quat_y;
        logic signed [Q_W-1:0]   quat_z;
    } t_out;

    // Data that rides alongside the square root pipeline.
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        t_sgn                    d_x;     // sign of r21 - r12
        t_sgn                    d_y;     // sign of r02 - r20
        t_sgn                    d_z;     // sign of r10 - r01
        t_sgn                    s_r10;
        t_sgn                    s_r20;
        t_sgn                    s_r21;
    } t_side;

endpackage

`default_nettype wire

### rtl/core/rm2q_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module rm2q_sqrt
    import rm2q_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [ROOT_W-1:0] i_adv,
    input  wire logic [SQ_W-1:0]   i_rad,
    output logic [ROOT_W-1:0]      o_root
);

    // One result bit per stage, restoring digit-by-digit square root.
    logic [SQ_W-1:0]   r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [SQ_W-1:0]    w_rad;
        logic [REM_W-1:0]   w_rem;
        logic [ROOT_W-1:0]  w_root;
        logic [REM_W+1:0]   w_trial;
        logic [REM_W+1:0]   w_sub;
        logic [SQ_W-1:0]    n_rad;
        logic [REM_W-1:0]   n_rem;
        logic [ROOT_W-1:0]  n_root;

        // The first stage starts from the incoming radicand.
        if (g == 0) begin : g_first
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_rad  = r_rad[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
        end

        // Bring down two radicand bits and try to subtract 4q + 1.
        always_comb begin
            w_trial = {w_rem, w_rad[SQ_W-1 -: 2]};
            w_sub   = (REM_W + 2)'({w_root, 2'b01});
            n_rad   = w_rad << 2;
            if (w_trial >= w_sub) begin
                n_rem  = REM_W'(w_trial - w_sub);
                n_root = {w_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(w_trial);
                n_root = {w_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[g]) begin
                r_rad[g]  <= n_rad;
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/core/rotation_matrix_to_quaternion.sv
// A transaction passes the trace, radicand, square root, select and output stages from accept to o_valid.
// Throughput: one transaction per cycle when not stalled; the four square roots each take one root bit per stage.
// Bubbles close up under stall through a per-stage ready chain, so input is taken while a
// finished result waits as long as any stage is empty.
// Reset (synchronous, active low) clears all stage valid bits and zero_threshold to 0.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion
    import rm2q_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire t_in              i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_out                  o_data,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata
);

    // Stage map.
    localparam int S_T   = 0;            // trace combinations
    localparam int S_RAD = 1;            // radicands
    localparam int S_SQ  = 2;            // first square root stage
    localparam int S_SEL = ROOT_W + 2;   // saturated magnitudes and chosen signs
    localparam int S_OUT = ROOT_W + 3;   // output register
    localparam int NST   = ROOT_W + 4;

    // Lanes of the four magnitudes.
    localparam int L_W = 0;
    localparam int L_X = 1;
    localparam int L_Y = 2;
    localparam int L_Z = 3;
    localparam int NL  = 4;

    logic [THR_W-1:0] r_zero_thr;
    logic [NST-1:0]   r_v;
    logic [NST:0]     w_rdy;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_thr <= '0;
        end else if (i_cfg_we) begin
            r_zero_thr <= i_cfg_wdata;
        end
    end

    // A stage takes new data when it is empty or its content moves on.
    always_comb begin
        w_rdy[NST] = !i_stall;
        for (int k = NST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[0];

    // Valid bits travel with the data.
    for (genvar g = 0; g < NST; g++) begin : g_valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (w_rdy[g]) begin
                if (g == 0) begin
                    r_v[g] <= i_valid;
                end else begin
                    r_v[g] <= r_v[(g == 0) ? 0 : g - 1];
                end
            end
        end
    end

    // Stage 0: signed trace combinations and sign information.
    logic signed [T_W-1:0] n_t [NL];
    logic signed [T_W-1:0] r_t [NL];
    logic signed [D_W-1:0] w_dx;
    logic signed [D_W-1:0] w_dy;
    logic signed [D_W-1:0] w_dz;
    t_side                 n_side0;

    always_comb begin
        n_t[L_W] =  T_W'(i_data.r00) + T_W'(i_data.r11) + T_W'(i_data.r22) + ONE_T;
        n_t[L_X] =  T_W'(i_data.r00) - T_W'(i_data.r11) - T_W'(i_data.r22) + ONE_T;
        n_t[L_Y] = -T_W'(i_data.r00) + T_W'(i_data.r11) - T_W'(i_data.r22) + ONE_T;
        n_t[L_Z] = -T_W'(i_data.r00) - T_W'(i_data.r11) + T_W'(i_data.r22) + ONE_T;
        w_dx = D_W'(i_data.r21) - D_W'(i_data.r12);
        w_dy = D_W'(i_data.r02) - D_W'(i_data.r20);
        w_dz = D_W'(i_data.r10) - D_W'(i_data.r01);
        n_side0.pos_x = i_data.pos_x;
        n_side0.pos_y = i_data.pos_y;
        n_side0.pos_z = i_data.pos_z;
        n_side0.d_x   = '{neg: w_dx[D_W-1], nz: |w_dx};
        n_side0.d_y   = '{neg: w_dy[D_W-1], nz: |w_dy};
        n_side0.d_z   = '{neg: w_dz[D_W-1], nz: |w_dz};
        n_side0.s_r10 = '{neg: i_data.r10[R_W-1], nz: |i_data.r10};
        n_side0.s_r20 = '{neg: i_data.r20[R_W-1], nz: |i_data.r20};
        n_side0.s_r21 = '{neg: i_data.r21[R_W-1], nz: |i_data.r21};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_T]) begin
            r_t <= n_t;
        end
    end

    // Side data shift line, one entry per stage up to the last root stage.
    t_side r_side [S_SEL];

    for (genvar g = 0; g < S_SEL; g++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_rdy[g]) begin
                if (g == 0) begin
                    r_side[g] <= n_side0;
                end else begin
                    r_side[g] <= r_side[(g == 0) ? 0 : g - 1];
                end
            end
        end
    end

    // Stage 1: absolute value, scaled into the radicand.
    logic [SQ_W-1:0]   r_rad  [NL];
    logic [ROOT_W-1:0] w_root [NL];

    for (genvar l = 0; l < NL; l++) begin : g_lane
        logic signed [T_W-1:0] w_abs;

        assign w_abs = r_t[l][T_W-1] ? -r_t[l] : r_t[l];

        always_ff @(posedge i_clk) begin
            if (w_rdy[S_RAD]) begin
                r_rad[l] <= SQ_W'({w_abs[ABS_W-1:0], {(FRAC_BITS - 2){1'b0}}});
            end
        end

        rm2q_sqrt u_sqrt (
            .i_clk  (i_clk),
            .i_adv  (w_rdy[S_SQ +: ROOT_W]),
            .i_rad  (r_rad[l]),
            .o_root (w_root[l])
        );
    end

    // Saturate each root at one.
    logic [MAG_W-1:0] w_mag [NL];

    for (genvar l = 0; l < NL; l++) begin : g_sat
        logic [SAT_W-1:0] w_ext;

        assign w_ext    = SAT_W'(w_root[l]);
        assign w_mag[l] = MAG_W'((w_ext > ONE_S) ? ONE_S : w_ext);
    end

    // Sign choice: off-diagonal differences, or the fallback chain when w is zero.
    logic w_w_nz;
    logic w_x_nz;
    logic w_y_nz;
    t_sgn n_sx;
    t_sgn n_sy;
    t_sgn n_sz;

    always_comb begin
        w_w_nz = w_mag[L_W] > MAG_W'(r_zero_thr);
        w_x_nz = w_mag[L_X] > MAG_W'(r_zero_thr);
        w_y_nz = w_mag[L_Y] > MAG_W'(r_zero_thr);
        if (w_w_nz) begin
            n_sx = r_side[S_SEL-1].d_x;
            n_sy = r_side[S_SEL-1].d_y;
            n_sz = r_side[S_SEL-1].d_z;
        end else begin
            n_sx = SGN_POS;
            if (w_x_nz) begin
                n_sy = r_side[S_SEL-1].s_r10;
                n_sz = r_side[S_SEL-1].s_r20;
            end else begin
                n_sy = SGN_POS;
                n_sz = w_y_nz ? r_side[S_SEL-1].s_r21 : SGN_POS;
            end
        end
    end

    logic [MAG_W-1:0]        r_mag [NL];
    t_sgn                    r_sx;
    t_sgn                    r_sy;
    t_sgn                    r_sz;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic signed [POS_W-1:0] r_pz;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_SEL]) begin
            r_mag <= w_mag;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sz  <= n_sz;
            r_px  <= r_side[S_SEL-1].pos_x;
            r_py  <= r_side[S_SEL-1].pos_y;
            r_pz  <= r_side[S_SEL-1].pos_z;
        end
    end

    // Output stage: apply the chosen signs to the vector parts.
    logic signed [Q_W-1:0] w_qx;
    logic signed [Q_W-1:0] w_qy;
    logic signed [Q_W-1:0] w_qz;
    t_out                  n_out;
    t_out                  r_out;

    always_comb begin
        w_qx = Q_W'(r_mag[L_X]);
        w_qy = Q_W'(r_mag[L_Y]);
        w_qz = Q_W'(r_mag[L_Z]);
        n_out.out_x  = r_px;
        n_out.out_y  = r_py;
        n_out.out_z  = r_pz;
        n_out.quat_w = r_mag[L_W];
        n_out.quat_x = r_sx.nz ? (r_sx.neg ? -w_qx : w_qx) : '0;
        n_out.quat_y = r_sy.nz ? (r_sy.neg ? -w_qy : w_qy) : '0;
        n_out.quat_z = r_sz.nz ? (r_sz.neg ? -w_qz : w_qz) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v[S_OUT];
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // Reset empties the pipeline.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An empty pipeline never pushes back on the input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) (r_v == '0) |-> !o_stall)
        else $error("stall with an empty pipeline");

    // Magnitudes are saturated at one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.quat_w <= ONE_M))
        else $error("quat_w above one");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.quat_x <= ONE_Q && o_data.quat_x >= -ONE_Q))
        else $error("quat_x out of range");
`endif

endmodule

`default_nettype wire
